// ===== rtl/ofdm_bit_inner_interleaver_assert.svh =====
// Assertion macros used by the checker file.
`ifndef OFDM_BIT_INNER_INTERLEAVER_ASSERT_SVH
`define OFDM_BIT_INNER_INTERLEAVER_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define OBII_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define OBII_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/obii_pkg.sv =====
package obii_pkg;

    localparam int BLOCK_LEN = 126;
    localparam int MAX_BITS  = 6;

    localparam int POS_W     = $clog2(BLOCK_LEN);
    localparam int ADDR_W    = POS_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_LEN - 1);

    localparam logic [POS_W-1:0] STREAM_OFFSET [MAX_BITS] = '{
        POS_W'(0), POS_W'(63), POS_W'(105), POS_W'(42), POS_W'(21), POS_W'(84)
    };

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULATION   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIERARCHICAL = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        MOD_QPSK  = 2'd0,
        MOD_16QAM = 2'd1,
        MOD_64QAM = 2'd2
    } t_mod;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic                en;
        t_addr               addr;
        logic [MAX_BITS-1:0] data;
    } t_wr_port;

endpackage

// ===== rtl/obii_stream_ram.sv =====
module obii_stream_ram
    import obii_pkg::*;
(
    input  logic                i_clk,
    input  t_wr_port            i_wr,
    input  logic                i_rd_en,
    input  t_addr               i_rd_addr [MAX_BITS],
    output logic [MAX_BITS-1:0] o_rd_data
);

    // one bit lane per stream: shared write address, own read address
    for (genvar g = 0; g < MAX_BITS; g++) begin : g_lane
        logic r_mem [RAM_DEPTH];
        logic r_q;

        always_ff @(posedge i_clk) begin
            if (i_wr.en) begin
                r_mem[i_wr.addr] <= i_wr.data[g];
            end
            if (i_rd_en) begin
                r_q <= r_mem[i_rd_addr[g]];
            end
        end

        assign o_rd_data[g] = r_q;
    end

endmodule

// ===== rtl/ofdm_bit_inner_interleaver.sv =====
// Channel   Dir  Signals                          Contents
// s         in   i_s_tvalid/o_s_tready/i_s_tdata  [5:0] hp_symbol, [9:6] lp_symbol
// m         out  o_m_tvalid/i_m_tready/o_m_tdata  [5:0] out_symbol, tlast block_last
// cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// One symbol per clock sustained while the output is not stalled; read stage, then output register.
// Each transfer writes one stream-RAM entry and reads six lanes of the other bank.
// Reset: position 0, bank 0; the first block is forced to zero output, no clear pass.
// Output register plus read stage each take a new item when free or draining.
// Output stall back-pressures the input after both stages fill.
module ofdm_bit_inner_interleaver
    import obii_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [15:0]           i_s_tdata,   // [5:0] hp_symbol, [9:6] lp_symbol

    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [5:0] out_symbol
    output logic                  o_m_tlast,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [1:0]          r_mode;
    logic                r_hier;
    logic [POS_W-1:0]    r_pos;
    logic                r_bank;
    logic                r_primed;

    logic                r_s1_valid;
    logic                r_s1_last;
    logic                r_s1_zero;
    logic [1:0]          r_s1_mode;

    logic                r_out_valid;
    logic [MAX_BITS-1:0] r_out_symbol;
    logic                r_out_last;

    logic                out_en;
    logic                s1_en;
    logic                in_xfer;
    logic                pos_last;
    logic [MAX_BITS-1:0] hp;
    logic [3:0]          lp;
    logic [MAX_BITS-1:0] wr_entry;
    t_wr_port            wr_port;
    t_addr               rd_addr [MAX_BITS];
    logic [MAX_BITS-1:0] rd_data;
    logic [MAX_BITS-1:0] n_out_symbol;

    assign out_en     = !r_out_valid || i_m_tready;
    assign s1_en      = !r_s1_valid || out_en;
    assign o_s_tready = s1_en;
    assign in_xfer    = i_s_tvalid && s1_en;
    assign pos_last   = (r_pos == LAST_POS);
    assign hp         = i_s_tdata[5:0];
    assign lp         = i_s_tdata[9:6];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MOD_QPSK;
            r_hier <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODULATION:   r_mode <= i_cfg_data;
                CFG_HIERARCHICAL: r_hier <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // demux: bit e of the entry belongs to stream e
    always_comb begin
        wr_entry = '0;
        if (r_hier && (r_mode != MOD_QPSK)) begin
            wr_entry[0] = hp[1];
            wr_entry[1] = hp[0];
            if (r_mode == MOD_16QAM) begin
                wr_entry[2] = lp[1];
                wr_entry[3] = lp[0];
            end else begin
                wr_entry[2] = lp[3];
                wr_entry[4] = lp[2];
                wr_entry[3] = lp[1];
                wr_entry[5] = lp[0];
            end
        end else begin
            case (r_mode)
                MOD_QPSK: begin
                    wr_entry[0] = hp[1];
                    wr_entry[1] = hp[0];
                end
                MOD_16QAM: begin
                    wr_entry[0] = hp[3];
                    wr_entry[2] = hp[2];
                    wr_entry[1] = hp[1];
                    wr_entry[3] = hp[0];
                end
                default: begin
                    wr_entry[0] = hp[5];
                    wr_entry[2] = hp[4];
                    wr_entry[4] = hp[3];
                    wr_entry[1] = hp[2];
                    wr_entry[3] = hp[1];
                    wr_entry[5] = hp[0];
                end
            endcase
        end
    end

    assign wr_port.en   = in_xfer;
    assign wr_port.addr = {r_bank, r_pos};
    assign wr_port.data = wr_entry;

    // read position (pos + offset) mod BLOCK_LEN, both operands below BLOCK_LEN
    always_comb begin
        logic [POS_W:0] sum;
        for (int e = 0; e < MAX_BITS; e++) begin
            sum = {1'b0, r_pos} + {1'b0, STREAM_OFFSET[e]};
            if (sum >= (POS_W+1)'(BLOCK_LEN)) begin
                sum = sum - (POS_W+1)'(BLOCK_LEN);
            end
            rd_addr[e] = {~r_bank, sum[POS_W-1:0]};
        end
    end

    obii_stream_ram u_ram (
        .i_clk     (i_clk),
        .i_wr      (wr_port),
        .i_rd_en   (in_xfer),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_bank   <= 1'b0;
            r_primed <= 1'b0;
        end else if (in_xfer) begin
            if (pos_last) begin
                r_pos    <= '0;
                r_bank   <= ~r_bank;
                r_primed <= 1'b1;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_en) begin
            r_s1_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_last <= pos_last;
            r_s1_zero <= !r_primed;
            r_s1_mode <= r_mode;
        end
    end

    // stream 0 lands in the most significant used bit
    always_comb begin
        case (r_s1_mode)
            MOD_QPSK:  n_out_symbol = {4'b0, rd_data[0], rd_data[1]};
            MOD_16QAM: n_out_symbol = {2'b0, rd_data[0], rd_data[1], rd_data[2], rd_data[3]};
            default:   n_out_symbol = {rd_data[0], rd_data[1], rd_data[2],
                                       rd_data[3], rd_data[4], rd_data[5]};
        endcase
        if (r_s1_zero) begin
            n_out_symbol = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_en) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid) begin
            r_out_symbol <= n_out_symbol;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b0, r_out_symbol};
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/obii_checker.sv =====
`include "ofdm_bit_inner_interleaver_assert.svh"

module obii_checker
    import obii_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic [15:0]           i_s_tdata,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [7:0]            o_m_tdata,
    input logic                  o_m_tlast,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic             in_xfer;
    logic             out_xfer;
    logic [1:0]       r_in_flight;
    logic [POS_W-1:0] r_out_cnt;
    logic             r_past_first;

    assign in_xfer  = i_s_tvalid && o_s_tready;
    assign out_xfer = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_flight  <= '0;
            r_out_cnt    <= '0;
            r_past_first <= 1'b0;
        end else begin
            r_in_flight <= r_in_flight + 2'(in_xfer) - 2'(out_xfer);
            if (out_xfer) begin
                if (r_out_cnt == LAST_POS) begin
                    r_out_cnt    <= '0;
                    r_past_first <= 1'b1;
                end else begin
                    r_out_cnt <= r_out_cnt + POS_W'(1);
                end
            end
        end
    end

    `OBII_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "output changed while stalled")

    `OBII_ASSERT_IMPLY(a_no_invent, out_xfer || (r_in_flight == 2'd3),
        (r_in_flight != 2'd0) && (r_in_flight != 2'd3), "output without pending input")

    `OBII_ASSERT_IMPLY(a_block_last, o_m_tvalid,
        o_m_tlast == (r_out_cnt == LAST_POS), "block_last off the block boundary")

    `OBII_ASSERT_IMPLY(a_first_zero, o_m_tvalid && !r_past_first,
        o_m_tdata == 8'd0, "first block output not zero")

endmodule

bind ofdm_bit_inner_interleaver obii_checker u_obii_checker (.*);
